FILE: rtl/aescbc_pkg.sv
// Shared types, constants and byte functions for the AES CBC/ECB PKCS7 engine.
// No dependencies; used by aescbc_keyexp, aescbc_round and the top level.
package aescbc_pkg;

    localparam int BLK_W  = 128;
    localparam int WORD_W = 32;
    localparam int ADDR_W = 6;
    localparam int RK_AW  = 4;

    localparam logic [1:0] KS_128 = 2'd0;
    localparam logic [1:0] KS_192 = 2'd1;
    localparam logic [1:0] KS_256 = 2'd2;

    localparam logic [2:0] REG_KEY0  = 3'd0;
    localparam logic [2:0] REG_KEY1  = 3'd1;
    localparam logic [2:0] REG_KEY2  = 3'd2;
    localparam logic [2:0] REG_KEY3  = 3'd3;
    localparam logic [2:0] REG_KSIZE = 3'd4;
    localparam logic [2:0] REG_OPER  = 3'd5;
    localparam logic [2:0] REG_IVH   = 3'd6;
    localparam logic [2:0] REG_IVL   = 3'd7;

    typedef struct packed {
        logic       start;
        logic [1:0] ks;
    } kx_req_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Key size three counts as 256-bit.
    function automatic logic [1:0] clamp_ks(input logic [1:0] ks);
        clamp_ks = (ks == 2'd3) ? KS_256 : ks;
    endfunction

    function automatic logic [3:0] round_count(input logic [1:0] ks);
        round_count = 4'd10 + {1'b0, clamp_ks(ks), 1'b0};
    endfunction

endpackage

FILE: rtl/aes_cbc_ecb_pkcs7_engine_core.sv
// AES engine, ECB or CBC, encrypt or decrypt, PKCS7 pad and check: top level.
// Depends on aescbc_pkg, aescbc_keyexp and aescbc_round.
//
// A block steps from its request through fetching the first round key, the
// initial key add, each round through the single shared round unit, and a
// finish step for chaining and padding. The first block after a key or key
// size write also waits for key expansion (one word per cycle).
// A last encrypt block with sixteen data bytes makes two results; the pad
// block runs the rounds again once the first result is taken. blk_stall is
// high from a request until its final result is taken. Registers sit at
// byte address 8*index on the 64-bit configuration port.
module aes_cbc_ecb_pkcs7_engine_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [aescbc_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready,
    input  logic                          blk_valid,
    output logic                          blk_stall,
    input  logic [63:0]                   data_high,
    input  logic [63:0]                   data_low,
    input  logic                          first_block,
    input  logic                          last_block,
    input  logic [4:0]                    valid_bytes,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [63:0]                   result_high,
    output logic [63:0]                   result_low,
    output logic [4:0]                    result_bytes,
    output logic                          last_result,
    output logic                          pad_error
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_EXPAND, ST_PREP, ST_ADDKEY, ST_ROUND, ST_FINISH, ST_HOLD
    } state_t;

    state_t      state_reg, state_next;
    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg, ivh_reg, ivl_reg;
    logic [1:0]  ksize_reg, oper_reg;
    logic        keys_ready_reg, keys_ready_next;
    logic [127:0] chain_reg, chain_next;
    logic [127:0] st_reg, st_next;
    logic [127:0] ct_reg, ct_next;
    logic        dec_reg, dec_next, cbc_reg, cbc_next;
    logic        last_reg, last_next, extra_reg, extra_next;
    logic [3:0]  ctr_reg, ctr_next;
    logic        res_valid_reg, res_valid_next;
    logic [127:0] res_reg, res_next;
    logic [4:0]  rbytes_reg, rbytes_next;
    logic        rlast_reg, rlast_next, rerr_reg, rerr_next;

    logic          wr_en, blk_acc;
    logic [2:0]    wr_idx;
    logic [3:0]    nr;
    logic [3:0]    rk_addr;
    logic [127:0]  rk;
    logic [127:0]  rnd_out;
    logic          kx_done;
    aescbc_pkg::kx_req_t kx_req;
    logic [4:0]    n_eff;
    logic [127:0]  blk_in, chain_eff, pt;
    logic [7:0]    pad_val;
    logic          pad_ok;
    logic          op_dec, op_cbc;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign wr_idx  = paddr[5:3];
    assign blk_acc = blk_valid & ~blk_stall;
    assign blk_stall = (state_reg != ST_IDLE);
    assign nr      = aescbc_pkg::round_count(ksize_reg);
    assign op_dec  = oper_reg[0];
    assign op_cbc  = oper_reg[1];

    always_comb
    begin
        case (wr_idx)
            aescbc_pkg::REG_KEY0:  prdata = key0_reg;
            aescbc_pkg::REG_KEY1:  prdata = key1_reg;
            aescbc_pkg::REG_KEY2:  prdata = key2_reg;
            aescbc_pkg::REG_KEY3:  prdata = key3_reg;
            aescbc_pkg::REG_KSIZE: prdata = {62'd0, ksize_reg};
            aescbc_pkg::REG_OPER:  prdata = {62'd0, oper_reg};
            aescbc_pkg::REG_IVH:   prdata = ivh_reg;
            default:               prdata = ivl_reg;
        endcase
    end

    assign kx_req.start = blk_acc & ~keys_ready_reg;
    assign kx_req.ks    = ksize_reg;

    aescbc_keyexp u_keyexp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (kx_req),
        .key     ({key0_reg, key1_reg, key2_reg, key3_reg}),
        .done    (kx_done),
        .rd_addr (rk_addr),
        .rk      (rk)
    );

    aescbc_round u_round
    (
        .din       (st_reg),
        .rk        (rk),
        .dec       (dec_reg),
        .final_rnd (ctr_reg == nr),
        .dout      (rnd_out)
    );

    // Key index fetched now is used in the next cycle.
    always_comb
    begin
        case (state_reg)
            ST_PREP:   rk_addr = dec_reg ? nr : 4'd0;
            ST_ADDKEY: rk_addr = dec_reg ? (nr - 4'd1) : 4'd1;
            ST_ROUND:  rk_addr = dec_reg ? (nr - ctr_reg - 4'd1) : (ctr_reg + 4'd1);
            default:   rk_addr = 4'd0;
        endcase
    end

    always_comb
    begin
        n_eff     = (valid_bytes > 5'd16) ? 5'd16 : valid_bytes;
        pad_val   = 8'd16 - {3'd0, n_eff};
        chain_eff = (op_cbc & first_block) ? {ivh_reg, ivl_reg} : chain_reg;
        blk_in    = {data_high, data_low};
        if (!op_dec && last_block)
            for (int i = 0; i < 16; i++)
                if (i[4:0] >= n_eff)
                    blk_in[127 - 8*i -: 8] = pad_val;
        if (!op_dec && op_cbc)
            blk_in = blk_in ^ chain_eff;

        pt     = st_reg ^ (cbc_reg ? chain_reg : 128'd0);
        pad_ok = (pt[7:0] >= 8'd1) && (pt[7:0] <= 8'd16);
        for (int i = 0; i < 16; i++)
            if ((8'(i) >= 8'd16 - pt[7:0]) && (pt[127 - 8*i -: 8] != pt[7:0]))
                pad_ok = 1'b0;
    end

    always_comb
    begin
        state_next      = state_reg;
        keys_ready_next = keys_ready_reg;
        chain_next      = chain_reg;
        st_next         = st_reg;
        ct_next         = ct_reg;
        dec_next        = dec_reg;
        cbc_next        = cbc_reg;
        last_next       = last_reg;
        extra_next      = extra_reg;
        ctr_next        = ctr_reg;
        res_valid_next  = res_valid_reg;
        res_next        = res_reg;
        rbytes_next     = rbytes_reg;
        rlast_next      = rlast_reg;
        rerr_next       = rerr_reg;

        if (wr_en && wr_idx <= aescbc_pkg::REG_KSIZE)
            keys_ready_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (blk_acc)
                begin
                    dec_next   = op_dec;
                    cbc_next   = op_cbc;
                    last_next  = last_block;
                    extra_next = ~op_dec & last_block & (n_eff == 5'd16);
                    ct_next    = {data_high, data_low};
                    st_next    = blk_in;
                    chain_next = chain_eff;
                    state_next = keys_ready_reg ? ST_PREP : ST_EXPAND;
                end
            end
            ST_EXPAND:
            begin
                if (kx_done)
                begin
                    keys_ready_next = 1'b1;
                    state_next      = ST_PREP;
                end
            end
            ST_PREP:
                state_next = ST_ADDKEY;
            ST_ADDKEY:
            begin
                st_next    = st_reg ^ rk;
                ctr_next   = 4'd1;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                st_next  = rnd_out;
                ctr_next = ctr_reg + 4'd1;
                if (ctr_reg == nr)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                res_valid_next = 1'b1;
                rerr_next      = 1'b0;
                rbytes_next    = 5'd16;
                if (!dec_reg)
                begin
                    res_next   = st_reg;
                    rlast_next = last_reg & ~extra_reg;
                    if (cbc_reg)
                        chain_next = st_reg;
                end
                else
                begin
                    res_next   = pt;
                    rlast_next = last_reg;
                    if (cbc_reg)
                        chain_next = ct_reg;
                    if (last_reg)
                    begin
                        rbytes_next = pad_ok ? (5'd16 - pt[4:0]) : 5'd0;
                        rerr_next   = ~pad_ok;
                    end
                end
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (!res_stall)
                begin
                    res_valid_next = 1'b0;
                    if (extra_reg)
                    begin
                        // Full last block: run the all-0x10 pad block next.
                        extra_next = 1'b0;
                        st_next    = {16{8'h10}} ^ (cbc_reg ? chain_reg : 128'd0);
                        state_next = ST_PREP;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            key0_reg       <= '0;
            key1_reg       <= '0;
            key2_reg       <= '0;
            key3_reg       <= '0;
            ksize_reg      <= '0;
            oper_reg       <= '0;
            ivh_reg        <= '0;
            ivl_reg        <= '0;
            keys_ready_reg <= 1'b0;
            chain_reg      <= '0;
            res_valid_reg  <= 1'b0;
            dec_reg        <= 1'b0;
            cbc_reg        <= 1'b0;
            last_reg       <= 1'b0;
            extra_reg      <= 1'b0;
            ctr_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            keys_ready_reg <= keys_ready_next;
            chain_reg      <= chain_next;
            res_valid_reg  <= res_valid_next;
            dec_reg        <= dec_next;
            cbc_reg        <= cbc_next;
            last_reg       <= last_next;
            extra_reg      <= extra_next;
            ctr_reg        <= ctr_next;
            if (wr_en)
            begin
                case (wr_idx)
                    aescbc_pkg::REG_KEY0:  key0_reg  <= pwdata;
                    aescbc_pkg::REG_KEY1:  key1_reg  <= pwdata;
                    aescbc_pkg::REG_KEY2:  key2_reg  <= pwdata;
                    aescbc_pkg::REG_KEY3:  key3_reg  <= pwdata;
                    aescbc_pkg::REG_KSIZE: ksize_reg <= pwdata[1:0];
                    aescbc_pkg::REG_OPER:  oper_reg  <= pwdata[1:0];
                    aescbc_pkg::REG_IVH:   ivh_reg   <= pwdata;
                    default:               ivl_reg   <= pwdata;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg     <= st_next;
        ct_reg     <= ct_next;
        res_reg    <= res_next;
        rbytes_reg <= rbytes_next;
        rlast_reg  <= rlast_next;
        rerr_reg   <= rerr_next;
    end

    assign res_valid    = res_valid_reg;
    assign result_high  = res_reg[127:64];
    assign result_low   = res_reg[63:0];
    assign result_bytes = rbytes_reg;
    assign last_result  = rlast_reg;
    assign pad_error    = rerr_reg;

    a_no_req_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> blk_stall)
        else $error("request taken while a result is pending");

    a_pad_err_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && pad_error) |-> (result_bytes == 5'd0 && last_result))
        else $error("padding error without zero byte count on a last result");

    a_enc_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !dec_reg) |-> (result_bytes == 5'd16 && !pad_error))
        else $error("encrypt result with short count or padding error");

    a_expand_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADDKEY) |-> keys_ready_reg)
        else $error("rounds started before key expansion finished");

endmodule

FILE: rtl/aescbc_keyexp.sv
// Iterative key expansion (one 32-bit word per cycle) and round key store.
// Depends on aescbc_pkg.
module aescbc_keyexp
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  aescbc_pkg::kx_req_t         req,
    input  logic [4*64-1:0]             key,
    output logic                        done,
    input  logic [aescbc_pkg::RK_AW-1:0] rd_addr,
    output logic [aescbc_pkg::BLK_W-1:0] rk
);

    logic [31:0] bank0 [16];
    logic [31:0] bank1 [16];
    logic [31:0] bank2 [16];
    logic [31:0] bank3 [16];

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  idx_reg, idx_next;
    logic [2:0]  mod_reg, mod_next;
    logic [7:0]  rcon_reg, rcon_next;
    logic [1:0]  ks_reg, ks_next;
    logic [31:0] win_reg [8];
    logic [31:0] word;
    logic [31:0] w_old;
    logic [31:0] tmp;
    logic [2:0]  nk;
    logic [5:0]  total;
    logic [31:0] rk0_q, rk1_q, rk2_q, rk3_q;

    always_comb
    begin
        case (ks_reg)
            aescbc_pkg::KS_128:
            begin
                nk    = 3'd4;
                total = 6'd43;
                w_old = win_reg[4];
            end
            aescbc_pkg::KS_192:
            begin
                nk    = 3'd6;
                total = 6'd51;
                w_old = win_reg[2];
            end
            default:
            begin
                nk    = 3'd0;
                total = 6'd59;
                w_old = win_reg[0];
            end
        endcase

        tmp = win_reg[7];
        if (mod_reg == 3'd0)
        begin
            tmp = {aescbc_pkg::SBOX[win_reg[7][23:16]] ^ rcon_reg,
                   aescbc_pkg::SBOX[win_reg[7][15:8]],
                   aescbc_pkg::SBOX[win_reg[7][7:0]],
                   aescbc_pkg::SBOX[win_reg[7][31:24]]};
        end
        else if (nk == 3'd0 && mod_reg == 3'd4)
        begin
            tmp = {aescbc_pkg::SBOX[win_reg[7][31:24]], aescbc_pkg::SBOX[win_reg[7][23:16]],
                   aescbc_pkg::SBOX[win_reg[7][15:8]],  aescbc_pkg::SBOX[win_reg[7][7:0]]};
        end

        // The first nk words come straight from the key.
        if ({1'b0, idx_reg} < ((nk == 3'd0) ? 7'd8 : {4'd0, nk}))
            word = key[255 - 32*idx_reg[2:0] -: 32];
        else
            word = w_old ^ tmp;

        busy_next = busy_reg;
        done_next = 1'b0;
        idx_next  = idx_reg;
        mod_next  = mod_reg;
        rcon_next = rcon_reg;
        ks_next   = ks_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            idx_next  = 6'd0;
            mod_next  = 3'd0;
            rcon_next = 8'h01;
            ks_next   = aescbc_pkg::clamp_ks(req.ks);
        end
        else if (busy_reg)
        begin
            idx_next = idx_reg + 6'd1;
            mod_next = (mod_reg == nk - 3'd1) ? 3'd0 : mod_reg + 3'd1;
            if (mod_reg == 3'd0 && idx_reg != 6'd0)
                rcon_next = aescbc_pkg::xtime(rcon_reg);
            if (idx_reg == total)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
            mod_reg  <= '0;
            rcon_reg <= 8'h01;
            ks_reg   <= aescbc_pkg::KS_128;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            idx_reg  <= idx_next;
            mod_reg  <= mod_next;
            rcon_reg <= rcon_next;
            ks_reg   <= ks_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            for (int j = 0; j < 7; j++)
                win_reg[j] <= win_reg[j+1];
            win_reg[7] <= word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            case (idx_reg[1:0])
                2'd0:    bank0[idx_reg[5:2]] <= word;
                2'd1:    bank1[idx_reg[5:2]] <= word;
                2'd2:    bank2[idx_reg[5:2]] <= word;
                default: bank3[idx_reg[5:2]] <= word;
            endcase
        end
        rk0_q <= bank0[rd_addr];
        rk1_q <= bank1[rd_addr];
        rk2_q <= bank2[rd_addr];
        rk3_q <= bank3[rd_addr];
    end

    assign rk   = {rk0_q, rk1_q, rk2_q, rk3_q};
    assign done = done_reg;

endmodule

FILE: rtl/aescbc_round.sv
// One AES round, forward or inverse, with the round key add.
// Depends on aescbc_pkg.
module aescbc_round
(
    input  logic [aescbc_pkg::BLK_W-1:0] din,
    input  logic [aescbc_pkg::BLK_W-1:0] rk,
    input  logic                         dec,
    input  logic                         final_rnd,
    output logic [aescbc_pkg::BLK_W-1:0] dout
);

    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] u [16];
    logic [7:0] a0, a1, a2, a3;
    logic [7:0] x0, x1, x2, x3;
    logic [7:0] y0, y1, y2, y3;
    logic [7:0] z0, z1, z2, z3;

    always_comb
    begin
        for (int i = 0; i < 16; i++)
            s[i] = din[127 - 8*i -: 8];
        for (int c = 0; c < 4; c++)
            for (int k = 0; k < 4; k++)
            begin
                if (dec)
                    t[((c + k) % 4) * 4 + k] = aescbc_pkg::INV_SBOX[s[c*4 + k]];
                else
                    t[c*4 + k] = aescbc_pkg::SBOX[s[((c + k) % 4) * 4 + k]];
            end
        // Inverse rounds add the key before mixing.
        if (dec)
            for (int i = 0; i < 16; i++)
                t[i] = t[i] ^ rk[127 - 8*i -: 8];
        for (int c = 0; c < 4; c++)
        begin
            a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
            x0 = aescbc_pkg::xtime(a0); x1 = aescbc_pkg::xtime(a1);
            x2 = aescbc_pkg::xtime(a2); x3 = aescbc_pkg::xtime(a3);
            y0 = aescbc_pkg::xtime(x0); y1 = aescbc_pkg::xtime(x1);
            y2 = aescbc_pkg::xtime(x2); y3 = aescbc_pkg::xtime(x3);
            z0 = aescbc_pkg::xtime(y0); z1 = aescbc_pkg::xtime(y1);
            z2 = aescbc_pkg::xtime(y2); z3 = aescbc_pkg::xtime(y3);
            if (final_rnd)
            begin
                u[c*4] = a0; u[c*4+1] = a1; u[c*4+2] = a2; u[c*4+3] = a3;
            end
            else if (dec)
            begin
                // 0e = 8^4^2, 0b = 8^2^1, 0d = 8^4^1, 09 = 8^1
                u[c*4]   = (z0^y0^x0) ^ (z1^x1^a1) ^ (z2^y2^a2) ^ (z3^a3);
                u[c*4+1] = (z0^a0) ^ (z1^y1^x1) ^ (z2^x2^a2) ^ (z3^y3^a3);
                u[c*4+2] = (z0^y0^a0) ^ (z1^a1) ^ (z2^y2^x2) ^ (z3^x3^a3);
                u[c*4+3] = (z0^x0^a0) ^ (z1^y1^a1) ^ (z2^a2) ^ (z3^y3^x3);
            end
            else
            begin
                u[c*4]   = x0 ^ x1 ^ a1 ^ a2 ^ a3;
                u[c*4+1] = a0 ^ x1 ^ x2 ^ a2 ^ a3;
                u[c*4+2] = a0 ^ a1 ^ x2 ^ x3 ^ a3;
                u[c*4+3] = x0 ^ a0 ^ a1 ^ a2 ^ x3;
            end
        end
        for (int i = 0; i < 16; i++)
            dout[127 - 8*i -: 8] = dec ? u[i] : (u[i] ^ rk[127 - 8*i -: 8]);
    end

endmodule
